FILE: design/led_pattern_generator_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the LED pattern generator.
// Both macros expect a clock named clk and a reset named rst in scope.
// ---------------------------------------------------------------------------
`ifndef LED_PATTERN_GENERATOR_UNIT_ASSERT_SVH
`define LED_PATTERN_GENERATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("LED pattern generator check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("LED pattern generator check failed");

`endif

FILE: design/lpg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED pattern generator package
// Shared constants, codes and record types for the LED pattern generator.
// ---------------------------------------------------------------------------
package lpg_pkg;

  // Number of LEDs served by the block.
  localparam int LED_COUNT = 8;
  localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  // Brightness scale: 2000 is full on.
  localparam int FULL_LEVEL      = 2000;
  localparam int BLINK_HIGH_MARK = 1800;
  localparam int MAX_TOP_HITS    = 3;

  localparam int LEVEL_W = 11;
  localparam int CFG_W   = 11;

  // Input word operation codes.
  typedef enum logic [1:0] {
    MODE_TICK      = 2'd0,
    MODE_SET       = 2'd1,
    MODE_RESET_ALL = 2'd2,
    MODE_READ      = 2'd3
  } mode_t;

  // Pattern codes.
  localparam logic [2:0] PAT_ON        = 3'd0;
  localparam logic [2:0] PAT_FAINT     = 3'd1;
  localparam logic [2:0] PAT_OFF       = 3'd2;
  localparam logic [2:0] PAT_BLINK     = 3'd3;
  localparam logic [2:0] PAT_SLOW_RAMP = 3'd4;
  localparam logic [2:0] PAT_FAST_RAMP = 3'd5;
  localparam logic [2:0] PAT_THREE_OFF = 3'd6;

  // Ramp direction codes; the unused code two behaves as down.
  localparam logic [1:0] DIR_FROZEN = 2'd0;
  localparam logic [1:0] DIR_UP     = 2'd1;
  localparam logic [1:0] DIR_DOWN   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_BLINK_PERIOD = 2'd0;
  localparam logic [1:0] REG_FAINT_LEVEL  = 2'd1;
  localparam logic [1:0] REG_SLOW_STEP    = 2'd2;
  localparam logic [1:0] REG_FAST_STEP    = 2'd3;

  // Per-LED state record as kept in the state memory.
  typedef struct packed {
    logic [2:0]         pattern;
    logic [LEVEL_W-1:0] level;
    logic [1:0]         dir;
    logic [2:0]         bcount;
    logic [10:0]        delay;
  } led_rec_t;

  // Configuration register set.
  typedef struct packed {
    logic [9:0]         blink_period;
    logic [LEVEL_W-1:0] faint_level;
    logic [LEVEL_W-1:0] slow_step;
    logic [LEVEL_W-1:0] fast_step;
  } cfg_t;

  // Control word from the sequencer to the step unit.
  typedef struct packed {
    mode_t      mode;
    logic [2:0] new_pattern;
  } step_ctrl_t;

endpackage

FILE: design/lpg_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED pattern generator channels
// Valid/ready channels for command words and result words.
// ---------------------------------------------------------------------------
interface lpg_in_if;
  import lpg_pkg::*;

  logic       valid;
  logic       ready;
  mode_t      mode;
  logic [7:0] led_index;
  logic [2:0] new_pattern;

  modport source (output valid, mode, led_index, new_pattern, input ready);
  modport sink (input valid, mode, led_index, new_pattern, output ready);
endinterface

interface lpg_out_if;
  import lpg_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [2:0]         current_pattern;
  logic               index_valid;

  modport source (output valid, level, current_pattern, index_valid, input ready);
  modport sink (input valid, level, current_pattern, index_valid, output ready);
endinterface

FILE: design/lpg_step_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED pattern generator step unit
// Computes the next state record of one LED for a tick, a set or a reset-all.
// ---------------------------------------------------------------------------
module lpg_step_unit
  import lpg_pkg::*;
(
  input  cfg_t       cfg,
  input  step_ctrl_t ctrl,
  input  led_rec_t   cur,
  output led_rec_t   nxt
);

  logic [LEVEL_W-1:0] step;
  logic [LEVEL_W:0]   up_sum;
  logic               dn_ok;
  logic [LEVEL_W-1:0] dn_diff;
  logic [10:0]        dly_inc;
  logic [2:0]         bc_inc;
  logic               is_three;
  logic [LEVEL_W-1:0] r_level;
  logic [1:0]         r_dir;
  logic [2:0]         r_bc;

  // Shared adder and subtractor for the ramps.
  assign step     = (cur.pattern == PAT_SLOW_RAMP) ? cfg.slow_step : cfg.fast_step;
  assign up_sum   = {1'b0, cur.level} + {1'b0, step};
  assign dn_ok    = cur.level >= step;
  assign dn_diff  = cur.level - step;
  assign dly_inc  = cur.delay + 11'd1;
  assign bc_inc   = cur.bcount + 3'd1;
  assign is_three = cur.pattern == PAT_THREE_OFF;

  // Ramp step: clamp at the ends and reverse on a strict overshoot.
  always_comb begin
    r_level = cur.level;
    r_dir   = cur.dir;
    r_bc    = cur.bcount;
    if (cur.dir[1]) begin
      if (dn_ok) begin
        r_level = dn_diff;
      end else begin
        r_level = '0;
        r_dir   = DIR_UP;
      end
    end else if (cur.dir == DIR_UP) begin
      if (up_sum > (LEVEL_W+1)'(FULL_LEVEL)) begin
        r_level = LEVEL_W'(FULL_LEVEL);
        r_dir   = DIR_DOWN;
        if (is_three) begin
          r_bc = bc_inc;
        end
      end else begin
        r_level = up_sum[LEVEL_W-1:0];
      end
    end
  end

  // Next record for the operation in progress.
  always_comb begin
    nxt = cur;
    unique case (ctrl.mode)
      MODE_TICK: begin
        unique case (cur.pattern)
          PAT_ON:    nxt.level = LEVEL_W'(FULL_LEVEL);
          PAT_FAINT: nxt.level = cfg.faint_level;
          PAT_OFF:   nxt.level = '0;
          PAT_BLINK: begin
            nxt.delay = dly_inc;
            if (dly_inc > {1'b0, cfg.blink_period}) begin
              nxt.level = (cur.level > LEVEL_W'(BLINK_HIGH_MARK)) ? '0 :
                          LEVEL_W'(FULL_LEVEL);
              nxt.delay = '0;
            end
          end
          PAT_SLOW_RAMP, PAT_FAST_RAMP, PAT_THREE_OFF: begin
            nxt.level  = r_level;
            nxt.dir    = r_dir;
            nxt.bcount = r_bc;
            if (is_three && (r_bc > 3'(MAX_TOP_HITS))) begin
              nxt.bcount  = '0;
              nxt.pattern = PAT_OFF;
            end
          end
          default: nxt = cur;
        endcase
      end
      MODE_SET: nxt.pattern = ctrl.new_pattern;
      MODE_RESET_ALL: begin
        nxt.pattern = PAT_OFF;
        nxt.dir     = DIR_UP;
      end
      MODE_READ: nxt = cur;
    endcase
  end

endmodule

FILE: design/led_pattern_generator_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED pattern generator
// Blink and breathe controller for LED_COUNT LEDs with one result per word.
// ---------------------------------------------------------------------------
// Each command word returns one result word for the LED named by led_index.
// The per-LED state lives in a small memory that one step unit reads and
// writes one LED at a time, in a read state and then an update state. A
// tick or a reset-all sweeps every LED before the block is ready again; a
// set that changes a pattern updates only that LED, and a read or an
// ignored set only fetches the entry. item.ready is high only when idle.
// A finished result waits in an output register, so the next command word is
// still taken; only the loading of that word's own result waits until the
// previous one has left. Configuration writes take effect at once and are
// expected only while the block is idle; faint_level and the step sizes
// saturate at 2000 when written.
module led_pattern_generator_unit
  import lpg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  lpg_in_if.sink           item,
  lpg_out_if.source        result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_FETCH,
    S_RESULT
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   ptr;
  logic               sweep;
  mode_t              mode_r;
  logic [7:0]         idx_r;
  logic [2:0]         np_r;
  logic               idx_ok_r;
  logic               out_valid;
  logic [LEVEL_W-1:0] out_level;
  logic [2:0]         out_pattern;
  logic               out_index_valid;
  cfg_t               cfg;
  led_rec_t           mem [LED_COUNT];
  logic [LED_COUNT-1:0] vld;
  led_rec_t           q;
  led_rec_t           nxt;
  step_ctrl_t         ctrl;
  logic               idx_ok;
  logic               accept;
  logic [CFG_W-1:0]   cfg_sat;
  logic               last_led;

  assign idx_ok   = {1'b0, item.led_index} < 9'(LED_COUNT);
  assign accept   = item.valid && item.ready;
  assign last_led = ptr == IDX_W'(LED_COUNT - 1);
  assign cfg_sat  = (cfg_data > CFG_W'(FULL_LEVEL)) ? CFG_W'(FULL_LEVEL) : cfg_data;

  assign item.ready             = state == S_IDLE;
  assign result.valid           = out_valid;
  assign result.level           = out_level;
  assign result.current_pattern = out_pattern;
  assign result.index_valid     = out_index_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blink_period <= 10'd100;
      cfg.faint_level  <= LEVEL_W'(200);
      cfg.slow_step    <= LEVEL_W'(1);
      cfg.fast_step    <= LEVEL_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLINK_PERIOD: cfg.blink_period <= cfg_data[9:0];
        REG_FAINT_LEVEL:  cfg.faint_level  <= cfg_sat;
        REG_SLOW_STEP:    cfg.slow_step    <= cfg_sat;
        REG_FAST_STEP:    cfg.fast_step    <= cfg_sat;
      endcase
    end
  end

  // Shared step unit.
  assign ctrl.mode        = mode_r;
  assign ctrl.new_pattern = np_r;

  lpg_step_unit u_step (
    .cfg  (cfg),
    .ctrl (ctrl),
    .cur  (q),
    .nxt  (nxt)
  );

  // State memory write port.
  always_ff @(posedge clk) begin
    if (state == S_UPDATE) begin
      mem[ptr] <= nxt;
    end
  end

  // Entry valid bits: an entry never written reads as all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (state == S_UPDATE) begin
      vld[ptr] <= 1'b1;
    end
  end

  // State memory read port with registered data.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      q <= vld[ptr] ? mem[ptr] : '0;
    end else if (state == S_FETCH) begin
      q <= vld[idx_r[IDX_W-1:0]] ? mem[idx_r[IDX_W-1:0]] : '0;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ptr       <= '0;
      sweep     <= 1'b0;
    end else begin
      if (result.ready && out_valid && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mode_r   <= item.mode;
            idx_r    <= item.led_index;
            np_r     <= item.new_pattern;
            idx_ok_r <= idx_ok;
            unique case (item.mode)
              MODE_TICK, MODE_RESET_ALL: begin
                ptr   <= '0;
                sweep <= 1'b1;
                state <= S_READ;
              end
              MODE_SET: begin
                ptr   <= item.led_index[IDX_W-1:0];
                sweep <= 1'b0;
                state <= (idx_ok && (item.new_pattern <= PAT_THREE_OFF)) ? S_READ : S_FETCH;
              end
              MODE_READ: begin
                sweep <= 1'b0;
                state <= S_FETCH;
              end
            endcase
          end
        end
        S_READ: state <= S_UPDATE;
        S_UPDATE: begin
          if (sweep && !last_led) begin
            ptr   <= ptr + IDX_W'(1);
            state <= S_READ;
          end else begin
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_RESULT;
        S_RESULT: begin
          if (!out_valid || result.ready) begin
            out_valid       <= 1'b1;
            out_level       <= idx_ok_r ? q.level : '0;
            out_pattern     <= idx_ok_r ? q.pattern : PAT_ON;
            out_index_valid <= idx_ok_r;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the block's own behavior.
`include "led_pattern_generator_unit_assert.svh"

  `LPG_ASSERT_NEXT(a_busy_after_accept, accept, !item.ready)
  `LPG_ASSERT_SAME(a_bad_index_zero, out_valid && !out_index_valid, (out_level == '0) && (out_pattern == PAT_ON))
  `LPG_ASSERT_SAME(a_level_in_range, out_valid, out_level <= LEVEL_W'(FULL_LEVEL))

endmodule
